// ===== hw/rtl/amp_pkg.sv =====
`default_nettype none
package amp_pkg;

	localparam int ANGLE_FRAC_BITS = 8;
	localparam int ANGLE_W = 24;
	localparam int FULL_TURN = 360 * (2 ** ANGLE_FRAC_BITS);
	localparam int HALF_TURN = FULL_TURN / 2;

	// 360 = 45 * 8, so a full turn is 45 shifted left by (frac + 3).
	localparam int MOD_SHIFT = ANGLE_FRAC_BITS + 3;
	localparam int MOD_DIV = 45;
	localparam int RECIP_SHIFT = 20;
	localparam int RECIP = (2 ** RECIP_SHIFT + MOD_DIV - 1) / MOD_DIV;
	localparam int MOD_OFFS = (2 ** ANGLE_W + HALF_TURN) / FULL_TURN + 1;

	localparam int DELTA_W = 18;
	localparam int TARGET_W = 25;
	localparam int SPEED_W = 23;
	localparam int SPEED_MAX = 4194303;
	localparam int SQ_W = 44;
	localparam int SQ_ITER = SQ_W / 2;
	localparam int SQ_STAGES = SQ_ITER / 2;

	localparam logic [2:0] REG_KEEPOUT_EN = 3'd0;
	localparam logic [2:0] REG_ZONE_START = 3'd1;
	localparam logic [2:0] REG_ZONE_END = 3'd2;
	localparam logic [2:0] REG_TRAVEL_EN = 3'd3;
	localparam logic [2:0] REG_TRAVEL_MIN = 3'd4;
	localparam logic [2:0] REG_TRAVEL_MAX = 3'd5;
	localparam logic [2:0] REG_ACCEL_LIMIT = 3'd6;
	localparam logic [2:0] REG_ACCEL_SCALE = 3'd7;

	typedef struct packed {
		logic signed [DELTA_W-1:0] delta;
		logic signed [TARGET_W-1:0] target;
		logic blocked;
	} pay_t;

	typedef struct packed {
		logic [SQ_W-1:0] x;
		logic [SQ_W-1:0] r;
	} sq_t;

	function automatic sq_t sq_step(sq_t s, logic [SQ_W-1:0] b);
		sq_t o;
		o = s;
		if (s.x >= s.r + b) begin
			o.x = s.x - (s.r + b);
			o.r = (s.r >> 1) + b;
		end else begin
			o.r = s.r >> 1;
		end
		return o;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/amp_mod.sv =====
`default_nettype none
module amp_mod (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic signed [25:0] x,
	output logic [16:0] r
);

	logic [25:0] y_s1;
	logic [25:0] y_s2;
	logic [8:0] q_s2;
	logic [16:0] r_s3;
	logic signed [26:0] y_sum;
	logic [29:0] prod;
	logic [25:0] qf;

	assign y_sum = 27'(x) + 27'(amp_pkg::MOD_OFFS * amp_pkg::FULL_TURN);
	assign prod = 30'(y_s1[25:amp_pkg::MOD_SHIFT]) * 30'(amp_pkg::RECIP);
	assign qf = 26'(q_s2) * 26'(amp_pkg::FULL_TURN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			y_s1 <= '0;
			y_s2 <= '0;
			q_s2 <= '0;
			r_s3 <= '0;
		end else if (en) begin
			y_s1 <= y_sum[25:0];
			y_s2 <= y_s1;
			q_s2 <= prod[amp_pkg::RECIP_SHIFT +: 9];
			r_s3 <= 17'(y_s2 - qf);
		end
	end

	assign r = r_s3;

endmodule
`default_nettype wire

// ===== hw/rtl/amp_sqrt.sv =====
`default_nettype none
module amp_sqrt (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic in_valid,
	input wire logic [amp_pkg::SQ_W-1:0] in_x,
	input wire amp_pkg::pay_t in_pay,
	output logic out_valid,
	output logic [amp_pkg::SQ_W-1:0] out_root,
	output amp_pkg::pay_t out_pay
);

	logic v_q [amp_pkg::SQ_STAGES+1];
	amp_pkg::sq_t s_q [amp_pkg::SQ_STAGES+1];
	amp_pkg::pay_t p_q [amp_pkg::SQ_STAGES+1];

	assign v_q[0] = in_valid;
	assign s_q[0] = '{x: in_x, r: '0};
	assign p_q[0] = in_pay;

	for (genvar k = 0; k < amp_pkg::SQ_STAGES; k++) begin : g_stage
		localparam int B0 = amp_pkg::SQ_W - 2 - 4 * k;
		localparam int B1 = B0 - 2;
		amp_pkg::sq_t a;
		amp_pkg::sq_t b;
		assign a = amp_pkg::sq_step(s_q[k], amp_pkg::SQ_W'(1) << B0);
		assign b = amp_pkg::sq_step(a, amp_pkg::SQ_W'(1) << B1);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k+1] <= 1'b0;
			end else if (en) begin
				v_q[k+1] <= v_q[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				s_q[k+1] <= b;
				p_q[k+1] <= p_q[k];
			end
		end
	end

	assign out_valid = v_q[amp_pkg::SQ_STAGES];
	assign out_root = s_q[amp_pkg::SQ_STAGES].r;
	assign out_pay = p_q[amp_pkg::SQ_STAGES];

endmodule
`default_nettype wire

// ===== hw/rtl/angle_move_planner_keepout.sv =====
// Throughput: one beat per cycle; the whole pipeline advances together and
// holds while the output beat waits for m_tready.
// The speed square root runs as 11 stages of two bits each.
// Reset clears all valid bits and returns the configuration registers to their defaults.
`default_nettype none
module angle_move_planner_keepout (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	// current_angle[23:0], target_angle[47:24]
	input wire logic [47:0] s_tdata,
	output logic m_tvalid,
	input wire logic m_tready,
	// move_delta[17:0], move_target[42:18], move_speed[65:43], zero fill
	output logic [71:0] m_tdata,
	// blocked[0]
	output logic m_tuser,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [2:0] cfg_index,
	input wire logic [23:0] cfg_data
);

	localparam logic signed [24:0] H25 = 25'(amp_pkg::HALF_TURN);
	localparam logic signed [17:0] H18 = 18'(amp_pkg::HALF_TURN);
	localparam logic signed [17:0] F18 = 18'(amp_pkg::FULL_TURN);
	localparam logic signed [19:0] F20 = 20'(amp_pkg::FULL_TURN);

	logic keepout_en_q, travel_en_q;
	logic signed [23:0] zone_start_q, zone_end_q, travel_min_q, travel_max_q;
	logic [23:0] accel_limit_q;
	logic [15:0] accel_scale_q;
	logic [39:0] accel_q;
	logic [16:0] zs, ze;
	logic zone_wrap_q, zone_empty_q;
	logic signed [19:0] za_lo_q [5];
	logic signed [19:0] za_hi_q [5];
	logic signed [19:0] zb_lo_q [5];
	logic signed [19:0] zb_hi_q [5];

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic signed [23:0] cur_s1, cur_s2, cur_s3, cur_s4, cur_s5, cur_s6, cur_s7;
	logic signed [24:0] diff_s1, diff_s2, diff_s3, diff_s4;
	logic signed [25:0] x_s1;
	logic [16:0] m_mod, ns_mod;
	logic [16:0] ns_s5;
	logic signed [17:0] d_s5, alt_s5, d_s6, alt_s6, d_s7, alt_s7;
	logic signed [18:0] nlo_s6 [2];
	logic signed [18:0] nhi_s6 [2];
	logic signed [25:0] alo_s6 [2];
	logic signed [25:0] ahi_s6 [2];
	logic nz_s6 [2];
	logic ok_s7 [2];
	amp_pkg::pay_t pay_s8, pay_s9;
	logic [16:0] mag_s8;
	logic [amp_pkg::SQ_W-1:0] x_s9;

	logic signed [24:0] tgt_in, cur_in;
	logic in_range;
	logic signed [17:0] d_wrap, d_pick, alt_pick;
	logic signed [18:0] nsum [2];
	logic signed [25:0] asum [2];
	logic signed [17:0] tries [2];
	logic ok_c [2];
	logic signed [17:0] dsel;
	logic [56:0] prod;
	logic sq_v;
	logic [amp_pkg::SQ_W-1:0] sq_root;
	amp_pkg::pay_t sq_pay;
	logic [21:0] smag;
	logic signed [22:0] speed;
	logic out_valid_q;
	logic [71:0] out_data_q;
	logic out_blk_q;

	assign cfg_ready = 1'b1;
	assign en = !out_valid_q || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keepout_en_q <= 1'b0;
			travel_en_q <= 1'b0;
			zone_start_q <= '0;
			zone_end_q <= '0;
			travel_min_q <= '0;
			travel_max_q <= '0;
			accel_limit_q <= '0;
			accel_scale_q <= 16'd16384;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				amp_pkg::REG_KEEPOUT_EN: keepout_en_q <= cfg_data[0];
				amp_pkg::REG_ZONE_START: zone_start_q <= cfg_data;
				amp_pkg::REG_ZONE_END: zone_end_q <= cfg_data;
				amp_pkg::REG_TRAVEL_EN: travel_en_q <= cfg_data[0];
				amp_pkg::REG_TRAVEL_MIN: travel_min_q <= cfg_data;
				amp_pkg::REG_TRAVEL_MAX: travel_max_q <= cfg_data;
				amp_pkg::REG_ACCEL_LIMIT: accel_limit_q <= cfg_data;
				amp_pkg::REG_ACCEL_SCALE: accel_scale_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	amp_mod u_mod_zs (.clk, .arst_n, .en(1'b1), .x(26'(zone_start_q)), .r(zs));
	amp_mod u_mod_ze (.clk, .arst_n, .en(1'b1), .x(26'(zone_end_q)), .r(ze));

	always_ff @(posedge clk) begin
		accel_q <= 40'(accel_limit_q) * 40'(accel_scale_q);
		zone_wrap_q <= zs > ze;
		zone_empty_q <= zs == ze;
		for (int k = 0; k < 5; k++) begin
			za_lo_q[k] <= 20'(zs) + 20'(k - 2) * F20;
			za_hi_q[k] <= ((zs > ze) ? F20 : 20'(ze)) + 20'(k - 2) * F20;
			zb_lo_q[k] <= 20'(k - 2) * F20;
			zb_hi_q[k] <= 20'(ze) + 20'(k - 2) * F20;
		end
	end

	assign cur_in = 25'(signed'(s_tdata[23:0]));
	assign tgt_in = 25'(signed'(s_tdata[47:24]));

	amp_mod u_mod_d (.clk, .arst_n, .en, .x(x_s1), .r(m_mod));
	amp_mod u_mod_ns (.clk, .arst_n, .en, .x(26'(cur_s1)), .r(ns_mod));

	always_comb begin
		in_range = (diff_s4 <= H25) && (diff_s4 >= -H25);
		if (in_range) begin
			d_wrap = diff_s4[17:0];
		end else if (m_mod == '0 && diff_s4 > 25'sd0) begin
			d_wrap = H18;
		end else begin
			d_wrap = $signed({1'b0, m_mod}) - H18;
		end
		d_pick = d_wrap;
		alt_pick = (d_wrap > 18'sd0) ? d_wrap - F18 : d_wrap + F18;
	end

	always_comb begin
		tries[0] = d_s5;
		tries[1] = alt_s5;
		for (int j = 0; j < 2; j++) begin
			nsum[j] = $signed({2'b0, ns_s5}) + 19'(tries[j]);
			asum[j] = 26'(cur_s5) + 26'(tries[j]);
		end
	end

	always_comb begin
		for (int j = 0; j < 2; j++) begin
			logic zhit;
			logic tbad;
			zhit = 1'b0;
			for (int k = 0; k < 5; k++) begin
				if (20'(nlo_s6[j]) < za_hi_q[k] && za_lo_q[k] < 20'(nhi_s6[j])) begin
					zhit = 1'b1;
				end
				if (zone_wrap_q && 20'(nlo_s6[j]) < zb_hi_q[k] &&
				    zb_lo_q[k] < 20'(nhi_s6[j])) begin
					zhit = 1'b1;
				end
			end
			zhit = zhit && nz_s6[j] && !zone_empty_q;
			tbad = alo_s6[j] < 26'(travel_min_q) || ahi_s6[j] > 26'(travel_max_q);
			ok_c[j] = !(keepout_en_q && zhit) && !(travel_en_q && tbad);
		end
	end

	always_comb begin
		if (ok_s7[0]) begin
			dsel = d_s7;
		end else if (ok_s7[1]) begin
			dsel = alt_s7;
		end else begin
			dsel = '0;
		end
	end

	assign prod = 57'(accel_q) * 57'(mag_s8);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cur_s1 <= cur_in[23:0];
			diff_s1 <= tgt_in - cur_in;
			x_s1 <= 26'(tgt_in - cur_in) + 26'(amp_pkg::HALF_TURN);
			cur_s2 <= cur_s1;
			diff_s2 <= diff_s1;
			cur_s3 <= cur_s2;
			diff_s3 <= diff_s2;
			cur_s4 <= cur_s3;
			diff_s4 <= diff_s3;
			cur_s5 <= cur_s4;
			ns_s5 <= ns_mod;
			d_s5 <= d_pick;
			alt_s5 <= alt_pick;
			cur_s6 <= cur_s5;
			d_s6 <= d_s5;
			alt_s6 <= alt_s5;
			for (int j = 0; j < 2; j++) begin
				nlo_s6[j] <= (tries[j] < 0) ? nsum[j] : $signed({2'b0, ns_s5});
				nhi_s6[j] <= (tries[j] < 0) ? $signed({2'b0, ns_s5}) : nsum[j];
				alo_s6[j] <= (tries[j] < 0) ? asum[j] : 26'(cur_s5);
				ahi_s6[j] <= (tries[j] < 0) ? 26'(cur_s5) : asum[j];
				nz_s6[j] <= tries[j] != '0;
				ok_s7[j] <= ok_c[j];
			end
			cur_s7 <= cur_s6;
			d_s7 <= d_s6;
			alt_s7 <= alt_s6;
			pay_s8.delta <= dsel;
			pay_s8.target <= 25'(cur_s7) + 25'(dsel);
			pay_s8.blocked <= !ok_s7[0] && !ok_s7[1];
			mag_s8 <= (dsel < 0) ? 17'(-dsel) : 17'(dsel);
			pay_s9 <= pay_s8;
			x_s9 <= prod[56:13];
		end
	end

	amp_sqrt u_sqrt (
		.clk,
		.arst_n,
		.en,
		.in_valid(v_s9),
		.in_x(x_s9),
		.in_pay(pay_s9),
		.out_valid(sq_v),
		.out_root(sq_root),
		.out_pay(sq_pay)
	);

	always_comb begin
		smag = (sq_root > 44'(amp_pkg::SPEED_MAX)) ? 22'(amp_pkg::SPEED_MAX) : sq_root[21:0];
		speed = (sq_pay.delta < 0) ? -$signed({1'b0, smag}) : $signed({1'b0, smag});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= sq_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= {6'd0, speed, sq_pay.target, sq_pay.delta};
			out_blk_q <= sq_pay.blocked;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;
	assign m_tuser = out_blk_q;

endmodule
`default_nettype wire

// ===== tb/angle_move_planner_keepout_tb.sv =====
`default_nettype none
module angle_move_planner_keepout_tb;

	typedef struct {
		logic [amp_pkg::DELTA_W-1:0] delta;
		logic [amp_pkg::TARGET_W-1:0] target;
		logic [amp_pkg::SPEED_W-1:0] speed;
		logic blocked;
	} move_t;

	class move_ledger;
		move_t expected_moves[$];
		int errors;
		bit keepout_on;
		logic signed [23:0] zone_lo_reg;
		logic signed [23:0] zone_hi_reg;
		bit travel_on;
		logic signed [23:0] travel_lo;
		logic signed [23:0] travel_hi;
		longint unsigned accel;
		longint unsigned scale;

		function new();
			errors = 0;
			keepout_on = 0;
			zone_lo_reg = 0;
			zone_hi_reg = 0;
			travel_on = 0;
			travel_lo = 0;
			travel_hi = 0;
			accel = 0;
			scale = 16384;
		endfunction

		function void write_reg(logic [2:0] idx, logic [23:0] val);
			case (idx)
				amp_pkg::REG_KEEPOUT_EN: keepout_on = val[0];
				amp_pkg::REG_ZONE_START: zone_lo_reg = val;
				amp_pkg::REG_ZONE_END: zone_hi_reg = val;
				amp_pkg::REG_TRAVEL_EN: travel_on = val[0];
				amp_pkg::REG_TRAVEL_MIN: travel_lo = val;
				amp_pkg::REG_TRAVEL_MAX: travel_hi = val;
				amp_pkg::REG_ACCEL_LIMIT: accel = 64'(val);
				amp_pkg::REG_ACCEL_SCALE: scale = 64'(val[15:0]);
				default: ;
			endcase
		endfunction

		function longint wrap_mod(longint v, longint m);
			longint r;
			r = v % m;
			return (r < 0) ? r + m : r;
		endfunction

		function longint shortest(longint d);
			longint h;
			longint r;
			h = longint'(amp_pkg::FULL_TURN) / 2;
			if (d > h) begin
				r = wrap_mod(d - h, amp_pkg::FULL_TURN);
				return (r == 0) ? h : r - amp_pkg::FULL_TURN + h;
			end
			if (d < -h)
				return wrap_mod(d + h, amp_pkg::FULL_TURN) - h;
			return d;
		endfunction

		function bit sweep_hits(longint s, longint d, longint zlo, longint zhi);
			longint lo;
			longint hi;
			longint a;
			longint b;
			longint off;
			if (d == 0)
				return 0;
			lo = (d < 0) ? s + d : s;
			hi = (d < 0) ? s : s + d;
			for (int k = -2; k <= 2; k++) begin
				off = longint'(amp_pkg::FULL_TURN) * k;
				a = (lo > zlo + off) ? lo : zlo + off;
				b = (hi < zhi + off) ? hi : zhi + off;
				if (a < b)
					return 1;
			end
			return 0;
		endfunction

		function bit path_ok(longint cur, longint d);
			longint ns;
			longint zs;
			longint ze;
			longint lo;
			longint hi;
			if (keepout_on) begin
				ns = wrap_mod(cur, amp_pkg::FULL_TURN);
				zs = wrap_mod(longint'(zone_lo_reg), amp_pkg::FULL_TURN);
				ze = wrap_mod(longint'(zone_hi_reg), amp_pkg::FULL_TURN);
				if (zs < ze && sweep_hits(ns, d, zs, ze))
					return 0;
				if (zs > ze && (sweep_hits(ns, d, zs, amp_pkg::FULL_TURN) ||
				    sweep_hits(ns, d, 0, ze)))
					return 0;
			end
			if (travel_on) begin
				lo = (d < 0) ? cur + d : cur;
				hi = (d < 0) ? cur : cur + d;
				if (lo < longint'(travel_lo) || hi > longint'(travel_hi))
					return 0;
			end
			return 1;
		endfunction

		function longint unsigned root_floor(longint unsigned x);
			longint unsigned r;
			longint unsigned c;
			r = 0;
			for (int b = 31; b >= 0; b--) begin
				c = r | (64'd1 << b);
				if (c * c <= x)
					r = c;
			end
			return r;
		endfunction

		function void note_request(logic signed [23:0] cur_a, logic signed [23:0] tgt_a);
			longint cur;
			longint d;
			longint alt;
			longint spd;
			longint unsigned mag;
			bit blk;
			move_t m;
			cur = longint'(cur_a);
			d = shortest(longint'(tgt_a) - cur);
			blk = 0;
			spd = 0;
			if (!path_ok(cur, d)) begin
				alt = (d > 0) ? d - amp_pkg::FULL_TURN : d + amp_pkg::FULL_TURN;
				if (path_ok(cur, alt))
					d = alt;
				else begin
					d = 0;
					blk = 1;
				end
			end
			if (!blk && d != 0) begin
				mag = (d < 0) ? -d : d;
				mag = root_floor((accel * scale * mag) >> 13);
				if (mag > amp_pkg::SPEED_MAX)
					mag = 64'(amp_pkg::SPEED_MAX);
				spd = (d < 0) ? -longint'(mag) : longint'(mag);
			end
			m.delta = d[amp_pkg::DELTA_W-1:0];
			m.target = amp_pkg::TARGET_W'(cur + d);
			m.speed = spd[amp_pkg::SPEED_W-1:0];
			m.blocked = blk;
			expected_moves.push_back(m);
		endfunction

		function void check_move(logic [71:0] data, logic usr);
			move_t e;
			if (expected_moves.size() == 0) begin
				$display("%0t: unexpected output beat %h/%b", $time, data, usr);
				errors++;
				return;
			end
			e = expected_moves.pop_front();
			if (data[17:0] !== e.delta) begin
				$display("%0t: move_delta expected %h actual %h", $time, e.delta, data[17:0]);
				errors++;
			end
			if (data[42:18] !== e.target) begin
				$display("%0t: move_target expected %h actual %h", $time, e.target,
					data[42:18]);
				errors++;
			end
			if (data[65:43] !== e.speed) begin
				$display("%0t: move_speed expected %h actual %h", $time, e.speed, data[65:43]);
				errors++;
			end
			if (usr !== e.blocked) begin
				$display("%0t: blocked expected %b actual %b", $time, e.blocked, usr);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [47:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [71:0] m_tdata;
	logic m_tuser;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [23:0] cfg_data;

	move_ledger ledger;
	int send_idle_pct;
	int stall_pct;
	int hold_cycles;
	int quiet_cycles;

	angle_move_planner_keepout DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			m_tready = 0;
			hold_cycles--;
		end else
			m_tready = ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			ledger.check_move(m_tdata, m_tuser);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= 3000) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task send_move(logic [23:0] cur, logic [23:0] tgt);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid = 0;
			@(negedge clk);
		end
		s_tvalid = 1;
		s_tdata = {tgt, cur};
		do @(posedge clk); while (!s_tready);
		ledger.note_request(cur, tgt);
		@(negedge clk);
		s_tvalid = 0;
	endtask

	task write_cfg(logic [2:0] idx, logic [23:0] val);
		cfg_valid = 1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		ledger.write_reg(idx, val);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task drain;
		while (ledger.expected_moves.size() != 0)
			@(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	task set_all(int ko, int zs, int ze, int te, int tmin, int tmax, int al, int sc);
		drain();
		write_cfg(amp_pkg::REG_KEEPOUT_EN, 24'(ko));
		write_cfg(amp_pkg::REG_ZONE_START, 24'(zs));
		write_cfg(amp_pkg::REG_ZONE_END, 24'(ze));
		write_cfg(amp_pkg::REG_TRAVEL_EN, 24'(te));
		write_cfg(amp_pkg::REG_TRAVEL_MIN, 24'(tmin));
		write_cfg(amp_pkg::REG_TRAVEL_MAX, 24'(tmax));
		write_cfg(amp_pkg::REG_ACCEL_LIMIT, 24'(al));
		write_cfg(amp_pkg::REG_ACCEL_SCALE, 24'(sc));
	endtask

	task random_moves(int n);
		int cur;
		int tgt;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(1)) begin
				cur = $urandom;
				tgt = $urandom;
			end else begin
				cur = int'($urandom_range(552960)) - 276480;
				tgt = cur + int'($urandom_range(102400)) - 51200;
			end
			send_move(cur[23:0], tgt[23:0]);
		end
	endtask

	int deg;
	int directed_pairs[0:19];

	initial begin
		ledger = new();
		deg = 256;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = 0;
		m_tready = 0;
		cfg_valid = 0;
		cfg_index = 0;
		cfg_data = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		hold_cycles = 0;
		quiet_cycles = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		random_moves(40);

		set_all(1, 90 * deg, 180 * deg, 1, -540 * deg, 540 * deg, 1000, 16384);
		directed_pairs = '{0, 180 * deg, 0, -180 * deg, 5 * deg, 5 * deg,
			-8388608, 8388607, 8388607, -8388608, 80 * deg, 100 * deg,
			170 * deg, 60 * deg, 530 * deg, 30 * deg, -530 * deg, -170 * deg, 0, 1};
		for (int i = 0; i < 20; i += 2)
			send_move(directed_pairs[i][23:0], directed_pairs[i + 1][23:0]);

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_all(1, 300 * deg, 30 * deg, 1, -720 * deg, 720 * deg,
					16777215, 65535);
				1: set_all(1, 45 * deg, 45 * deg + 360 * deg, 1, 10 * deg, -10 * deg,
					4096, 20000);
				2: set_all(1, -8388608, 8388607, 1, -8388608, 8388607, 123456, 0);
				default: set_all($urandom_range(1), $urandom, $urandom, $urandom_range(1),
					-int'($urandom_range(300000)), $urandom_range(300000),
					$urandom, $urandom_range(65535));
			endcase
			send_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 3) ? 31 : 45) : 0;
			stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? ((ph % 4 == 3) ? 31 : 45) : 0;
			if (ph == 0)
				hold_cycles = 400;
			random_moves(150);
			drain();
			random_moves(140);
		end

		drain();
		if (ledger.errors == 0 && ledger.expected_moves.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
`default_nettype wire
